// ----- src/sha_pkg.sv -----
// ----------------------------------------------------------------------------
// SHA-256 shared definitions
// Queue entry type, initial hash values, round constants and round functions.
// ----------------------------------------------------------------------------
package sha_pkg;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_valid;
    logic       last_item;
  } sha_item_t;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam int         LEN_BYTES  = 8;
  localparam int         BLK_BYTES  = 64;
  localparam logic [5:0] LEN_START  = 6'(BLK_BYTES - LEN_BYTES);

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

// ----- src/sha_front.sv -----
// ----------------------------------------------------------------------------
// SHA-256 front end
// Accepts input transactions, drops empty ones and queues the rest.
// ----------------------------------------------------------------------------
module sha_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,
  input  logic              in_tuser,
  input  logic              in_tlast,
  output logic              q_valid,
  input  logic              q_pop,
  output sha_pkg::sha_item_t q_item
);
  import sha_pkg::*;

  localparam int DEPTH = 4;

  sha_item_t  mem_r [DEPTH];
  logic [1:0] wptr_r, wptr_nxt;
  logic [1:0] rptr_r, rptr_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_tready = (cnt_r != 3'(DEPTH));
  // An item with neither a byte nor an end mark changes nothing.
  assign push      = in_tvalid && in_tready && (in_tuser || in_tlast);
  assign q_valid   = (cnt_r != 3'd0);
  assign q_item    = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = push  ? wptr_r + 2'd1 : wptr_r;
    rptr_nxt = q_pop ? rptr_r + 2'd1 : rptr_r;
    cnt_nxt  = cnt_r + 3'(push) - 3'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= '{msg_byte: in_tdata, byte_valid: in_tuser, last_item: in_tlast};
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(DEPTH)) else $error("queue count above depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> cnt_r != 3'd0) else $error("pop from empty queue");
`endif

endmodule

// ----- src/sha_core.sv -----
// ----------------------------------------------------------------------------
// SHA-256 back end
// Block assembly, padding, one-round-per-cycle compression and digest output.
// ----------------------------------------------------------------------------
module sha_core #(
  parameter int LENGTH_BITS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_pop,
  input  sha_pkg::sha_item_t q_item,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [2:0]         out_widx,
  output logic [31:0]        out_word,
  output logic               out_tlast
);
  import sha_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_PAD    = 6'b000010,
    S_LEN    = 6'b000100,
    S_ROUND  = 6'b001000,
    S_FINISH = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

  state_t                 st_r, st_nxt;
  logic [5:0]             rnd_r;
  logic                   last_pend_r, last_pend_nxt;
  logic                   emit_after_r, emit_after_nxt;
  logic                   len_after_r, len_after_nxt;
  logic [2:0]             widx_r, widx_nxt;
  logic [LENGTH_BITS-1:0] cnt_r;
  logic [31:0]            chain_r [8];
  logic [31:0]            wv_r [8];
  logic [31:0]            win_r [16];
  logic                   start_cmp;
  logic                   out_done;
  logic [5:0]             pos;
  logic [63:0]            len64;
  logic [31:0]            t1, t2, w_new;

  assign pos        = cnt_r[8:3];
  assign out_tvalid = (st_r == S_EMIT);
  assign out_widx   = widx_r;
  assign out_word   = chain_r[widx_r];
  assign out_tlast  = (widx_r == 3'd7);
  assign out_done   = out_tvalid && out_tready && out_tlast;

  always_comb begin
    len64 = '0;
    len64[LENGTH_BITS-1:0] = cnt_r;
  end

  assign t1 = wv_r[7] + bsig1(wv_r[4]) + ((wv_r[4] & wv_r[5]) ^ (~wv_r[4] & wv_r[6]))
            + ROUND_K[rnd_r] + win_r[0];
  assign t2 = bsig0(wv_r[0]) + ((wv_r[0] & wv_r[1]) ^ (wv_r[0] & wv_r[2]) ^ (wv_r[1] & wv_r[2]));
  assign w_new = sig1(win_r[14]) + win_r[9] + sig0(win_r[1]) + win_r[0];

  always_comb begin
    st_nxt         = st_r;
    last_pend_nxt  = last_pend_r;
    emit_after_nxt = emit_after_r;
    len_after_nxt  = len_after_r;
    widx_nxt       = widx_r;
    q_pop          = 1'b0;
    start_cmp      = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.byte_valid && pos == 6'(BLK_BYTES - 1)) begin
            start_cmp      = 1'b1;
            last_pend_nxt  = q_item.last_item;
            emit_after_nxt = 1'b0;
            len_after_nxt  = 1'b0;
            st_nxt         = S_ROUND;
          end else if (q_item.last_item) begin
            st_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        start_cmp     = 1'b1;
        last_pend_nxt = 1'b0;
        // No room for the length field: it goes into an extra block.
        len_after_nxt  = (pos >= LEN_START);
        emit_after_nxt = (pos < LEN_START);
        st_nxt         = S_ROUND;
      end
      S_LEN: begin
        start_cmp      = 1'b1;
        len_after_nxt  = 1'b0;
        emit_after_nxt = 1'b1;
        st_nxt         = S_ROUND;
      end
      S_ROUND: begin
        if (rnd_r == 6'd63) begin
          st_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (emit_after_r) begin
          st_nxt = S_EMIT;
        end else if (len_after_r) begin
          st_nxt = S_LEN;
        end else if (last_pend_r) begin
          st_nxt = S_PAD;
        end else begin
          st_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_tready) begin
          widx_nxt = widx_r + 3'd1;
          if (out_tlast) begin
            emit_after_nxt = 1'b0;
            st_nxt         = S_IDLE;
          end
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      rnd_r        <= '0;
      last_pend_r  <= 1'b0;
      emit_after_r <= 1'b0;
      len_after_r  <= 1'b0;
      widx_r       <= '0;
      cnt_r        <= '0;
      chain_r      <= IV;
    end else begin
      st_r         <= st_nxt;
      last_pend_r  <= last_pend_nxt;
      emit_after_r <= emit_after_nxt;
      len_after_r  <= len_after_nxt;
      widx_r       <= widx_nxt;
      if (st_r == S_ROUND) begin
        rnd_r <= rnd_r + 6'd1;
      end
      if (q_pop && q_item.byte_valid) begin
        cnt_r <= cnt_r + LENGTH_BITS'(8);
      end else if (out_done) begin
        cnt_r <= '0;
      end
      if (st_r == S_FINISH) begin
        for (int i = 0; i < 8; i++) begin
          chain_r[i] <= chain_r[i] + wv_r[i];
        end
      end else if (out_done) begin
        chain_r <= IV;
      end
    end
  end

  // Working variables.
  always_ff @(posedge clk) begin
    if (start_cmp) begin
      wv_r <= chain_r;
    end else if (st_r == S_ROUND) begin
      wv_r[0] <= t1 + t2;
      wv_r[1] <= wv_r[0];
      wv_r[2] <= wv_r[1];
      wv_r[3] <= wv_r[2];
      wv_r[4] <= wv_r[3] + t1;
      wv_r[5] <= wv_r[4];
      wv_r[6] <= wv_r[5];
      wv_r[7] <= wv_r[6];
    end
  end

  // Block words double as the rolling schedule window.
  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: begin
        if (q_pop && q_item.byte_valid) begin
          win_r[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= q_item.msg_byte;
        end
      end
      S_PAD: begin
        for (int j = 0; j < BLK_BYTES; j++) begin
          if (6'(j) == pos) begin
            win_r[j / 4][(3 - j % 4) * 8 +: 8] <= PAD_BYTE;
          end else if (6'(j) > pos) begin
            win_r[j / 4][(3 - j % 4) * 8 +: 8] <= 8'h00;
          end
        end
        if (pos < LEN_START) begin
          win_r[14] <= len64[63:32];
          win_r[15] <= len64[31:0];
        end
      end
      S_LEN: begin
        for (int k = 0; k < 14; k++) begin
          win_r[k] <= '0;
        end
        win_r[14] <= len64[63:32];
        win_r[15] <= len64[31:0];
      end
      S_ROUND: begin
        for (int k = 0; k < 15; k++) begin
          win_r[k] <= win_r[k + 1];
        end
        win_r[15] <= w_new;
      end
      default: begin
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_ROUND && rnd_r == 6'd63) |=> st_r == S_FINISH)
    else $error("compression did not finish after round 63");
  a_msg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_done |=> (cnt_r == '0 && chain_r[0] == IV[0] && chain_r[7] == IV[7]))
    else $error("state not restored after digest");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> st_r == S_IDLE) else $error("queue popped while busy");
  a_round_idle: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != S_ROUND |-> rnd_r == 6'd0) else $error("round counter not at zero");
`endif

endmodule

// ----- src/sha256_digest_engine.sv -----
// ----------------------------------------------------------------------------
// SHA-256 digest engine
// Hashes a byte stream and returns the 256-bit digest as eight 32-bit words.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload
//  in_*     slave      tdata[7:0] message byte, tuser byte valid, tlast end
//  out_*    master     tdata[2:0] word index, tdata[34:3] digest word, tlast
//
// A byte that does not complete a block is absorbed while the back end is idle. The 64th
// byte of a block starts a compression of 64 rounds at one round per cycle, set by
// the single round unit, followed by the chaining add; the back end takes no further
// byte from the queue until that compression is through. An end-of-message
// transaction costs one or two further compressions plus eight output words.
// A four-entry queue lets the input keep accepting while the back end works.
// Reset is synchronous, active low, and returns the engine to an empty message.
module sha256_digest_engine #(
  parameter int LENGTH_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] msg_byte
  input  logic        in_tuser,   // [0] byte_valid
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [2:0] word_index, [34:3] digest_word, zero fill
  output logic        out_tlast
);
  import sha_pkg::*;

  sha_item_t   q_item;
  logic        q_valid;
  logic        q_pop;
  logic [2:0]  widx;
  logic [31:0] word;

  sha_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item)
  );

  sha_core #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_item     (q_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_widx   (widx),
    .out_word   (word),
    .out_tlast  (out_tlast)
  );

  // The output words come straight from registers of the back end.
  assign out_tdata = {5'b00000, word, widx};

endmodule

// ----- verif/tb_sha256_digest_engine.sv -----
// ----------------------------------------------------------------------------
// SHA-256 digest engine testbench
// Streams byte messages into the engine and checks every digest word against
// a behavioral SHA-256 model kept in the bench, under random idling on both
// channels, a long receiver hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module tb_sha256_digest_engine;
  import sha_pkg::*;

  typedef struct {
    logic [7:0] msg_byte;
    logic       byte_valid;
    logic       last_item;
    logic       has_known; // digest word 0 typed in below
    logic [31:0] known_h0;
  } stim_row_t;

  typedef struct {
    logic [2:0]  word_index;
    logic [31:0] digest_word;
    logic        last_word;
  } digest_word_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] msg_byte
  logic        in_tuser;   // [0] byte_valid
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [2:0] word_index, [34:3] digest_word, zero fill
  logic        out_tlast;

  sha256_digest_engine u_top (.*);

  // Bench copy of the hashing state.
  logic [31:0] chain_h [8];
  logic [7:0]  blk_buf [64];
  logic [63:0] msg_bits;

  digest_word_t digest_q[$];
  int unsigned  n_fail;
  int unsigned  n_words;
  int unsigned  n_msgs;
  int unsigned  n_sent;
  bit           calm;       // no idling in the final stretch
  bit           hold_off;   // long receiver stall in progress

  function automatic logic [31:0] rr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_buf();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] wr, t1, t2, a, e;
    int r;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
    for (int i = 0; i < 8; i++) v[i] = chain_h[i];
    for (r = 0; r < 64; r++) begin
      if (r < 16) begin
        wr = w[r];
      end else begin
        a = w[(r - 15) & 15];
        e = w[(r - 2) & 15];
        wr = w[r & 15] + (rr(a, 7) ^ rr(a, 18) ^ (a >> 3)) + w[(r - 7) & 15]
             + (rr(e, 17) ^ rr(e, 19) ^ (e >> 10));
        w[r & 15] = wr;
      end
      t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + wr;
      t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_h[i] += v[i];
  endtask

  task automatic clear_hash();
    for (int i = 0; i < 8; i++) chain_h[i] = IV[i];
    msg_bits = '0;
  endtask

  // Absorbs one accepted transaction and queues any digest words it yields.
  task automatic hash_transaction(logic [7:0] b, logic bv, logic lst);
    int pos;
    digest_word_t d;
    if (bv) begin
      pos = int'(msg_bits[8:3]);
      blk_buf[pos] = b;
      msg_bits += 64'd8;
      if (pos == 63) compress_buf();
    end
    if (lst) begin
      pos = int'(msg_bits[8:3]);
      blk_buf[pos] = PAD_BYTE;
      for (int i = pos + 1; i < 64; i++) blk_buf[i] = '0;
      // Padding overflow: too little room for the length, add a block.
      if (pos >= 56) begin
        compress_buf();
        for (int i = 0; i < 64; i++) blk_buf[i] = '0;
      end
      for (int i = 0; i < 8; i++) blk_buf[56 + i] = msg_bits[63 - 8*i -: 8];
      compress_buf();
      for (int i = 0; i < 8; i++) begin
        d.word_index  = 3'(i);
        d.digest_word = chain_h[i];
        d.last_word   = (i == 7);
        digest_q.push_back(d);
      end
      clear_hash();
      n_msgs++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("sha256_digest_engine test failed");
    $finish;
  end

  // Sends one transaction, with optional random idle ahead of it.
  task automatic send_item(logic [7:0] b, logic bv, logic lst);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= bv;
    in_tlast  <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    hash_transaction(b, bv, lst);
    n_sent++;
  endtask

  // Sends a whole message of len bytes with random content and optional noise.
  task automatic send_message(int len, bit noisy, bit end_on_byte);
    for (int i = 0; i < len; i++) begin
      if (noisy && $urandom_range(0, 7) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, (end_on_byte && i == len - 1));
    end
    if (!(end_on_byte && len > 0)) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off while the sender runs.
  initial begin
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Checker of digest words against the bench model.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (digest_q.size() == 0) begin
        n_fail++;
        if (n_fail <= 10) $display("unexpected digest word %h", out_tdata);
      end else begin
        digest_word_t d;
        d = digest_q.pop_front();
        n_words++;
        if (out_tdata[2:0] !== d.word_index || out_tdata[34:3] !== d.digest_word
            || out_tdata[39:35] !== 5'd0 || out_tlast !== d.last_word) begin
          n_fail++;
          if (n_fail <= 10)
            $display("mismatch: expected idx %0d word %h last %b, got idx %0d word %h last %b",
                     d.word_index, d.digest_word, d.last_word,
                     out_tdata[2:0], out_tdata[34:3], out_tlast);
        end
      end
    end
  end

  // Directed table: "abc", the empty message, ends combined with a byte,
  // extreme byte values and noise items; after it, a 56-byte message whose
  // length needs an extra block.
  stim_row_t dir_rows [$];

  task automatic add_row(logic [7:0] b, logic bv, logic lst,
                         logic kn = 1'b0, logic [31:0] h0 = '0);
    stim_row_t r;
    r.msg_byte = b; r.byte_valid = bv; r.last_item = lst;
    r.has_known = kn; r.known_h0 = h0;
    dir_rows.push_back(r);
  endtask

  initial begin
    int len;
    n_fail = 0; n_words = 0; n_msgs = 0; n_sent = 0;
    calm = 0; hold_off = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = 1'b0; in_tlast = 1'b0;
    for (int i = 0; i < 64; i++) blk_buf[i] = '0;
    clear_hash();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty message right after reset, then "abc" with the last byte closing it.
    add_row(8'h00, 1'b0, 1'b1, 1'b1, 32'he3b0c442);
    add_row(8'h61, 1'b1, 1'b0);
    add_row(8'h00, 1'b0, 1'b0);
    add_row(8'h62, 1'b1, 1'b0);
    add_row(8'h63, 1'b1, 1'b1, 1'b1, 32'hba7816bf);
    add_row(8'hff, 1'b1, 1'b0);
    add_row(8'hff, 1'b0, 1'b0);
    add_row(8'h00, 1'b1, 1'b0);
    add_row(8'hff, 1'b0, 1'b1);
    add_row(8'h55, 1'b1, 1'b1);
    add_row(8'haa, 1'b1, 1'b0);
    add_row(8'h00, 1'b0, 1'b1);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].has_known) begin
        send_item(dir_rows[i].msg_byte, dir_rows[i].byte_valid, dir_rows[i].last_item);
        if (digest_q[digest_q.size() - 8].digest_word !== dir_rows[i].known_h0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("known digest: expected %h, model %h", dir_rows[i].known_h0,
                     digest_q[digest_q.size() - 8].digest_word);
        end
      end else begin
        send_item(dir_rows[i].msg_byte, dir_rows[i].byte_valid, dir_rows[i].last_item);
      end
    end
    send_message(56, 1'b0, 1'b0);
    send_message(64, 1'b0, 1'b1);

    // Sender pause until every digest word has come back.
    wait_drain();

    // Receiver hold-off while short messages keep arriving.
    hold_off = 1'b1;
    for (int m = 0; m < 6; m++) send_message($urandom_range(0, 3), 1'b0, 1'b0);
    wait_drain();

    // Short random messages with noise items mixed in.
    while (n_sent < 170) begin
      case ($urandom_range(0, 2))
        0: len = $urandom_range(0, 4);
        default: len = $urandom_range(5, 12);
      endcase
      if (n_sent > 155) calm = 1'b1;
      send_message(len, 1'b1, 1'($urandom_range(0, 1)));
    end
    in_tvalid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("Covered %0d transactions in %0d messages, %0d digest words checked.",
             n_sent, n_msgs, n_words);
    if (n_fail == 0 && digest_q.size() == 0) begin
      $display("sha256_digest_engine test passed");
    end else begin
      $display("%0d mismatches, %0d words outstanding", n_fail, digest_q.size());
      $display("sha256_digest_engine test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/sha_pkg.sv
src/sha_front.sv
src/sha_core.sv
src/sha256_digest_engine.sv
verif/tb_sha256_digest_engine.sv
